>>> rtl/matrix_vector_multiply_unit_defines.svh
// Assertion macros for the matrix-vector multiply unit.
// Used by files that assert; each use expects clk_i and rst_ni in scope.
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// General property check, clocked on clk_i and quiet during reset.
`define MVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition in one cycle must be followed by another in the next cycle.
`define MVM_ASSERT_NEXT(label, cond, expect_nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expect_nxt)) \
    else $error(msg);

`endif

>>> rtl/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply unit.
// No dependencies; imported by every module of the block but mvm_ram.
package mvm_pkg;

  localparam int MAX_DIM_DEF = 16;  // default matrix dimension
  localparam int ROW_LIMIT   = 16;  // rows that a 4-bit row index can name
  localparam int SIZE_W      = 5;
  localparam int IDX_W       = 4;
  localparam int ELEM_W      = 16;
  localparam int SUM_W       = 32;
  localparam int MODE_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LD_MAT  = 2'd0,
    MODE_LD_VEC  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_mat;     // store elem_value into the matrix
    logic wr_vec;     // store elem_value into the vector
    logic issue;      // read one matrix/vector pair
    logic first_col;  // pair opens a row
    logic last_col;   // pair closes a row
    logic last_row;   // pair closes the final row
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;   // pipeline may move this cycle
    logic done;  // final row result enters the output register
  } status_t;

endpackage

>>> rtl/mvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mvm_ctrl.sv
// Controller: input handshake, size register and the row/column sequencer.
// Depends on mvm_pkg.
module mvm_ctrl #(
  parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF,
  localparam int CAP = (MAX_DIM < mvm_pkg::ROW_LIMIT) ? MAX_DIM : mvm_pkg::ROW_LIMIT,
  localparam int RW  = $clog2(CAP)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mvm_pkg::MODE_W-1:0]  mode_i,
  input  logic                        cfg_we_i,
  input  logic [mvm_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  mvm_pkg::status_t            status_i,
  output mvm_pkg::cmd_t               cmd_o,
  output logic [RW-1:0]               rd_row_o,
  output logic [RW-1:0]               rd_col_o
);
  import mvm_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] n_eff;
  logic [RW-1:0]     i_q, i_d, j_q, j_d;
  logic              i_last, j_last;

  always_comb begin
    if (size_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_q > SIZE_W'(CAP)) begin
      n_eff = SIZE_W'(CAP);
    end else begin
      n_eff = size_q;
    end
  end

  assign i_last = (SIZE_W'(i_q) == n_eff - SIZE_W'(1));
  assign j_last = (SIZE_W'(j_q) == n_eff - SIZE_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SIZE_W'(16);
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_LD_MAT:  cmd_o.wr_mat = 1'b1;
            MODE_LD_VEC:  cmd_o.wr_vec = 1'b1;
            MODE_COMPUTE: begin
              state_d = ST_RUN;
              i_d     = '0;
              j_d     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // One matrix/vector pair per cycle, frozen while the output is blocked.
        if (status_i.adv) begin
          cmd_o.issue     = 1'b1;
          cmd_o.first_col = (j_q == '0);
          cmd_o.last_col  = j_last;
          cmd_o.last_row  = i_last && j_last;
          if (j_last) begin
            j_d = '0;
            if (i_last) begin
              state_d = ST_DRAIN;
            end else begin
              i_d = i_q + RW'(1);
            end
          end else begin
            j_d = j_q + RW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (status_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rd_row_o = i_q;
  assign rd_col_o = j_q;

endmodule

>>> rtl/mvm_dpath.sv
// Datapath: matrix and vector stores, multiplier, accumulator, output register.
// Depends on mvm_pkg and mvm_ram.
module mvm_dpath #(
  parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF,
  localparam int CAP = (MAX_DIM < mvm_pkg::ROW_LIMIT) ? MAX_DIM : mvm_pkg::ROW_LIMIT,
  localparam int RW  = $clog2(CAP)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mvm_pkg::cmd_t                     cmd_i,
  input  logic [RW-1:0]                     rd_row_i,
  input  logic [RW-1:0]                     rd_col_i,
  input  logic [mvm_pkg::IDX_W-1:0]         row_sel_i,
  input  logic [mvm_pkg::IDX_W-1:0]         col_sel_i,
  input  logic signed [mvm_pkg::ELEM_W-1:0] elem_value_i,
  output mvm_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mvm_pkg::IDX_W-1:0]         row_index_o,
  output logic signed [mvm_pkg::SUM_W-1:0]  product_sum_o,
  output logic                              last_o
);
  import mvm_pkg::*;

  localparam int IW   = $clog2(MAX_DIM);
  localparam int AW   = $clog2(MAX_DIM * MAX_DIM);
  localparam int LW   = AW + IDX_W;
  localparam int VLW  = IW + IDX_W;
  localparam int CMPW = ($clog2(MAX_DIM + 1) > IDX_W) ? $clog2(MAX_DIM + 1) : IDX_W;

  logic              adv;
  logic              mat_in_range, vec_in_range;
  logic [LW-1:0]     mat_waddr_full, mat_raddr_full;
  logic [VLW-1:0]    vec_waddr_full;
  logic [ELEM_W-1:0] mat_rdata, vec_rdata;

  // Pipeline tags: stage 1 is the RAM read, stage 2 the product register.
  logic              v1_q, f1_q, lc1_q, lr1_q;
  logic [RW-1:0]     r1_q;
  logic              v2_q, f2_q, lc2_q, lr2_q;
  logic [RW-1:0]     r2_q;
  logic signed [SUM_W-1:0] prod_d, prod_q;
  logic signed [SUM_W-1:0] acc_d, acc_q;
  logic              row_end;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_row_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic              out_last_q;

  // The whole pipeline holds while a finished result waits on a stalled output.
  assign adv = !(out_valid_q && out_stall_i);

  assign mat_in_range = (CMPW'(row_sel_i) < CMPW'(MAX_DIM)) &&
                        (CMPW'(col_sel_i) < CMPW'(MAX_DIM));
  assign vec_in_range = (CMPW'(col_sel_i) < CMPW'(MAX_DIM));

  assign mat_waddr_full = LW'(row_sel_i) * LW'(MAX_DIM) + LW'(col_sel_i);
  assign mat_raddr_full = LW'(rd_row_i) * LW'(MAX_DIM) + LW'(rd_col_i);
  assign vec_waddr_full = VLW'(col_sel_i);

  mvm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_mat && mat_in_range),
    .waddr_i (mat_waddr_full[AW-1:0]),
    .wdata_i (elem_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (mat_raddr_full[AW-1:0]),
    .rdata_o (mat_rdata)
  );

  mvm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_vec && vec_in_range),
    .waddr_i (vec_waddr_full[IW-1:0]),
    .wdata_i (elem_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (IW'(rd_col_i)),
    .rdata_o (vec_rdata)
  );

  assign prod_d  = SUM_W'($signed(mat_rdata)) * SUM_W'($signed(vec_rdata));
  assign acc_d   = f2_q ? prod_q : acc_q + prod_q;
  assign row_end = adv && v2_q && lc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= cmd_i.issue;
        v2_q <= v1_q;
      end
      if (row_end) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q   <= cmd_i.first_col;
      lc1_q  <= cmd_i.last_col;
      lr1_q  <= cmd_i.last_row;
      r1_q   <= rd_row_i;
      f2_q   <= f1_q;
      lc2_q  <= lc1_q;
      lr2_q  <= lr1_q;
      r2_q   <= r1_q;
      prod_q <= prod_d;
    end
    if (adv && v2_q) begin
      acc_q <= acc_d;
    end
    if (row_end) begin
      out_sum_q  <= acc_d;
      out_row_q  <= IDX_W'(r2_q);
      out_last_q <= lr2_q;
    end
  end

  assign status_o.adv  = adv;
  assign status_o.done = row_end && lr2_q;

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = out_row_q;
  assign product_sum_o = out_sum_q;
  assign last_o        = out_last_q;

endmodule

>>> rtl/matrix_vector_multiply_unit.sv
// Top level of the matrix-vector multiply unit: controller plus datapath.
// Depends on mvm_pkg, mvm_ctrl, mvm_dpath and the assertion macro header.
//
//   Channel   Handshake                   Carries
//   input     in_valid_i / in_stall_o     mode_i, row_sel_i, col_sel_i, elem_value_i
//   output    out_valid_o / out_stall_i   row_index_o, product_sum_o, last_o
//   config    cfg_we_i                    cfg_wdata_i (size in use)
//
// Load requests stream back to back.
// A compute request holds off further input while it issues the n*n pairs of the single
// multiply-accumulate pipeline (one matrix/vector pair per cycle) and while it drains;
// the final result is presented at the edge that releases the input.
// A stalled output freezes that pipeline; results come out one per row, in row order.
// Reset clears the controller and valid flags; the stores hold garbage until loaded.
`include "matrix_vector_multiply_unit_defines.svh"

module matrix_vector_multiply_unit #(
  parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mvm_pkg::MODE_W-1:0]        mode_i,
  input  logic [mvm_pkg::IDX_W-1:0]         row_sel_i,
  input  logic [mvm_pkg::IDX_W-1:0]         col_sel_i,
  input  logic signed [mvm_pkg::ELEM_W-1:0] elem_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mvm_pkg::IDX_W-1:0]         row_index_o,
  output logic signed [mvm_pkg::SUM_W-1:0]  product_sum_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic [mvm_pkg::SIZE_W-1:0]        cfg_wdata_i
);
  import mvm_pkg::*;

  localparam int CAP = (MAX_DIM < ROW_LIMIT) ? MAX_DIM : ROW_LIMIT;
  localparam int RW  = $clog2(CAP);

  cmd_t          cmd;
  status_t       status;
  logic [RW-1:0] rd_row, rd_col;
  logic          store_wr;
  logic          compute_acc;

  mvm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .rd_row_o    (rd_row),
    .rd_col_o    (rd_col)
  );

  mvm_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_row_i      (rd_row),
    .rd_col_i      (rd_col),
    .row_sel_i     (row_sel_i),
    .col_sel_i     (col_sel_i),
    .elem_value_i  (elem_value_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_index_o   (row_index_o),
    .product_sum_o (product_sum_o),
    .last_o        (last_o)
  );

  assign store_wr    = cmd.wr_mat || cmd.wr_vec;
  assign compute_acc = in_valid_i && !in_stall_o && (mode_i == MODE_COMPUTE);

  // A store write never coincides with a compute read.
  `MVM_ASSERT(a_no_wr_during_read, !(cmd.issue && store_wr), "write during compute read")

  // An accepted compute request holds off further input in the next cycle.
  `MVM_ASSERT_NEXT(a_compute_blocks, compute_acc, in_stall_o, "compute did not block input")

  // The final row result is presented as the last one.
  `MVM_ASSERT_NEXT(a_done_shows_last, status.done, out_valid_o && last_o, "last not set")

endmodule

>>> tb/sv/tb_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_vector_multiply_unit: a directed table,
// then random load, compute and unused-mode requests across size settings, checked row by row.
// Depends on mvm_pkg and the RTL of the block only.
module tb_matrix_vector_multiply_unit;
  import mvm_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int ITEM_TARGET  = 430;
  localparam int REPORT_CAP   = 100;
  localparam int PLAN_LEN     = 17;
  localparam int SIZE_PHASES  = 10;
  localparam int PRESSURE_LEN = 12;

  localparam logic [MODE_W-1:0]        MODE_UNUSED = 2'd3;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN    = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX    = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] ELEM_ONES   = 16'shffff;
  localparam logic signed [ELEM_W-1:0] ELEM_ZERO   = 16'sh0000;
  localparam logic signed [SUM_W-1:0]  SUM_NONE    = 32'sh0;

  typedef struct packed {
    logic [IDX_W-1:0]        row_index;
    logic signed [SUM_W-1:0] product_sum;
    logic                    last;
  } row_result_t;

  // A row either writes the size register or offers one request. Rows with
  // n_typed set carry their row sums as written here instead of predicted.
  typedef struct packed {
    logic                     is_cfg;
    logic [SIZE_W-1:0]        size;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic [1:0]               n_typed;
    logic signed [SUM_W-1:0]  sum0;
    logic signed [SUM_W-1:0]  sum1;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{1'b1, 5'd2, MODE_LD_MAT,  4'd0,  4'd0,  ELEM_ZERO, 2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_MAT,  4'd0,  4'd0,  ELEM_MIN,  2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_MAT,  4'd0,  4'd1,  ELEM_MIN,  2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_MAT,  4'd1,  4'd0,  ELEM_MAX,  2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_MAT,  4'd1,  4'd1,  ELEM_ZERO, 2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_VEC,  4'd9,  4'd0,  ELEM_MIN,  2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_VEC,  4'd15, 4'd1,  ELEM_MIN,  2'd0, SUM_NONE, SUM_NONE},
    // Two products of the most negative element wrap the first row sum.
    '{1'b0, 5'd0, MODE_COMPUTE, 4'd0,  4'd0,  ELEM_ZERO, 2'd2,
      32'sh80000000, -32'sd1073709056},
    '{1'b0, 5'd0, MODE_UNUSED,  4'd15, 4'd15, ELEM_ONES, 2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_MAT,  4'd15, 4'd15, ELEM_MAX,  2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_VEC,  4'd0,  4'd15, ELEM_ONES, 2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_MAT,  4'd1,  4'd1,  ELEM_ONES, 2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_COMPUTE, 4'd15, 4'd15, ELEM_ONES, 2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_LD_VEC,  4'd0,  4'd1,  ELEM_MAX,  2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_COMPUTE, 4'd5,  4'd10, ELEM_MAX,  2'd0, SUM_NONE, SUM_NONE},
    // A size of zero behaves as one.
    '{1'b1, 5'd0, MODE_LD_MAT,  4'd0,  4'd0,  ELEM_ZERO, 2'd0, SUM_NONE, SUM_NONE},
    '{1'b0, 5'd0, MODE_COMPUTE, 4'd0,  4'd0,  ELEM_ZERO, 2'd1,
      32'sd1073741824, SUM_NONE}
  };

  localparam logic [SIZE_W-1:0] SIZE_PLAN [SIZE_PHASES] = '{
    5'd3, 5'd1, 5'd5, 5'd31, 5'd2, 5'd8, 5'd16, 5'd4, 5'd12, 5'd1
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        mode_i;
  logic [IDX_W-1:0]         row_sel_i;
  logic [IDX_W-1:0]         col_sel_i;
  logic signed [ELEM_W-1:0] elem_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [IDX_W-1:0]         row_index_o;
  logic signed [SUM_W-1:0]  product_sum_o;
  logic                     last_o;
  logic                     cfg_we_i;
  logic [SIZE_W-1:0]        cfg_wdata_i;

  matrix_vector_multiply_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .row_sel_i     (row_sel_i),
    .col_sel_i     (col_sel_i),
    .elem_value_i  (elem_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_index_o   (row_index_o),
    .product_sum_o (product_sum_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block's stores and size register.
  logic signed [ELEM_W-1:0] mat_shadow [MAX_DIM_DEF][MAX_DIM_DEF];
  logic signed [ELEM_W-1:0] vec_shadow [MAX_DIM_DEF];
  bit                       mat_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
  bit                       vec_loaded [MAX_DIM_DEF];
  logic [SIZE_W-1:0]        size_shadow;
  row_result_t              pending_rows [$];

  bit steady_flow;
  bit pressure_on;
  bit long_hold_done;
  int mismatches;
  int results_seen;
  int requests_sent;
  int real_requests;
  int computes;
  int sizes_written;
  int cycles;

  function automatic int rows_in_use();
    int n;
    n = int'(size_shadow);
    if (n == 0) n = 1;
    if (n > MAX_DIM_DEF) n = MAX_DIM_DEF;
    if (n > ROW_LIMIT) n = ROW_LIMIT;
    return n;
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_value();
    logic signed [ELEM_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = ELEM_MIN;
      1: v = ELEM_MAX;
      2: v = ELEM_ONES;
      default: v = ELEM_W'($urandom);
    endcase
    return v;
  endfunction

  // Applies one request to the shadow stores and queues the row results of a compute.
  task automatic advance_matvec(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col,
                                input logic signed [ELEM_W-1:0] value, input int n_typed,
                                input logic signed [SUM_W-1:0] sum0,
                                input logic signed [SUM_W-1:0] sum1);
    int n;
    int i;
    int j;
    int acc;
    row_result_t r;
    case (mode)
      MODE_LD_MAT: begin
        mat_shadow[row][col] = value;
        mat_loaded[row][col] = 1'b1;
      end
      MODE_LD_VEC: begin
        vec_shadow[col] = value;
        vec_loaded[col] = 1'b1;
      end
      MODE_COMPUTE: begin
        n = rows_in_use();
        computes++;
        for (i = 0; i < n; i++) begin
          acc = 0;
          for (j = 0; j < n; j++) acc += int'(mat_shadow[i][j]) * int'(vec_shadow[j]);
          if (n_typed != 0) acc = (i == 0) ? sum0 : sum1;
          r.row_index   = IDX_W'(i);
          r.product_sum = acc;
          r.last        = (i == n - 1);
          pending_rows.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Called in the step of a rising edge; returns in the step of the edge that
  // takes the request. The request is predicted as soon as it is offered,
  // because a compute may emit its rows while it still holds the input.
  task automatic offer_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col,
                               input logic signed [ELEM_W-1:0] value, input int n_typed,
                               input logic signed [SUM_W-1:0] sum0,
                               input logic signed [SUM_W-1:0] sum1);
    int gap;
    bit taken;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    row_sel_i    <= row;
    col_sel_i    <= col;
    elem_value_i <= value;
    advance_matvec(mode, row, col, value, n_typed, sum0, sum1);
    requests_sent++;
    if (mode != MODE_UNUSED) real_requests++;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] size);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_shadow = size;
    sizes_written++;
  endtask

  // Every entry that a compute at the current size reads must have been loaded.
  task automatic fill_unloaded();
    int n;
    int i;
    int j;
    n = rows_in_use();
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        if (!mat_loaded[i][j])
          offer_request(MODE_LD_MAT, IDX_W'(i), IDX_W'(j), pick_value(), 0, SUM_NONE, SUM_NONE);
      end
      if (!vec_loaded[i])
        offer_request(MODE_LD_VEC, IDX_W'($urandom), IDX_W'(i), pick_value(), 0,
                      SUM_NONE, SUM_NONE);
    end
  endtask

  task automatic random_request();
    int n;
    int pick;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    n = rows_in_use();
    pick = $urandom_range(0, 99);
    r = IDX_W'($urandom_range(0, n - 1));
    c = IDX_W'($urandom_range(0, n - 1));
    if ($urandom_range(0, 4) == 0) begin
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
    end
    if (pick < 45)
      offer_request(MODE_LD_MAT, r, c, pick_value(), 0, SUM_NONE, SUM_NONE);
    else if (pick < 70)
      offer_request(MODE_LD_VEC, IDX_W'($urandom), c, pick_value(), 0, SUM_NONE, SUM_NONE);
    else if (pick < 87)
      offer_request(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom), 0,
                    SUM_NONE, SUM_NONE);
    else
      offer_request(MODE_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom), 0,
                    SUM_NONE, SUM_NONE);
  endtask

  task automatic check_row_result();
    row_result_t want;
    results_seen++;
    if (pending_rows.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d sum %0d last %0d",
                                row_index_o, product_sum_o, last_o));
    end else begin
      want = pending_rows.pop_front();
      if (row_index_o !== want.row_index)
        report_mismatch($sformatf("row_index %0d, want %0d", row_index_o, want.row_index));
      if (product_sum_o !== want.product_sum)
        report_mismatch($sformatf("product_sum %0d, want %0d (row %0d)", product_sum_o,
                                  want.product_sum, want.row_index));
      if (last_o !== want.last)
        report_mismatch($sformatf("last %0d, want %0d (row %0d)", last_o, want.last,
                                  want.row_index));
    end
  endtask

  // Result side: a random hold-off before each result outside steady flow, and one long one.
  initial begin : result_sink
    int hold;
    bit taken;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 3);
      if (pressure_on && !long_hold_done) begin
        hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk_i);
        if (out_valid_o) begin
          check_row_result();
          taken = 1'b1;
        end
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
             pending_rows.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int k;
    int phase;
    int burst;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_LD_MAT;
    row_sel_i    <= '0;
    col_sel_i    <= '0;
    elem_value_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    size_shadow  = SIZE_W'(16);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < PLAN_LEN; k++) begin
      if (DIRECTED_PLAN[k].is_cfg)
        write_size(DIRECTED_PLAN[k].size);
      else
        offer_request(DIRECTED_PLAN[k].mode, DIRECTED_PLAN[k].row, DIRECTED_PLAN[k].col,
                      DIRECTED_PLAN[k].value, int'(DIRECTED_PLAN[k].n_typed),
                      DIRECTED_PLAN[k].sum0, DIRECTED_PLAN[k].sum1);
    end

    // Computes keep coming while the result side holds off, so the block fills up.
    pressure_on = 1'b1;
    repeat (PRESSURE_LEN)
      offer_request(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom), 0,
                    SUM_NONE, SUM_NONE);

    // Each phase picks a size, loads what that size still lacks, runs a mixed
    // burst and closes with a compute. Every third phase runs without gaps.
    phase = 0;
    while (requests_sent < ITEM_TARGET) begin
      write_size(SIZE_PLAN[phase % SIZE_PHASES]);
      steady_flow = (phase % 3 == 2);
      fill_unloaded();
      burst = $urandom_range(12, 30);
      repeat (burst) random_request();
      offer_request(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom), 0,
                    SUM_NONE, SUM_NONE);
      phase++;
    end

    settle_block();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests (%0d with a used mode, %0d computes) over %0d sizes.",
             requests_sent, real_requests, computes, sizes_written);
    $display("Output held off once for %0d cycles under load; %0d rows, %0d mismatches.",
             LONG_HOLD, results_seen, mismatches);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/mvm_ctrl.sv
rtl/mvm_dpath.sv
rtl/matrix_vector_multiply_unit.sv
tb/sv/tb_matrix_vector_multiply_unit.sv
